### rtl/energy_voice_segmenter_defines.svh
// ----------------------------------------------------------------------------
// energy_voice_segmenter_defines
// Assertion macros shared by the segmenter's checker.
// ----------------------------------------------------------------------------
`ifndef ENERGY_VOICE_SEGMENTER_DEFINES_SVH
`define ENERGY_VOICE_SEGMENTER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define EVS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EVS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/evs_pkg.sv
// ----------------------------------------------------------------------------
// evs_pkg
// Widths, types and helpers of the energy voice segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package evs_pkg;

  localparam int unsigned FRAME      = 256;
  localparam int unsigned DEPTH      = 2 * FRAME;
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned SUM_W      = 15 + $clog2(FRAME + 1);
  localparam int unsigned LIM_W      = MAG_W + 1 + $clog2(FRAME + 1);
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 3);

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [LIM_W-1:0] lim_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [THR_W-1:0] thr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THR  = 1'b0,
    CFG_HIGH_THR = 1'b1
  } cfg_idx_e;

  localparam thr_t LOW_THR_RST  = 16'd512;
  localparam thr_t HIGH_THR_RST = 16'd1024;

  // window state handed from the delay chain to the judge stage
  typedef struct packed {
    logic judge;
    logic last;
    sum_t cur_sum;
    sum_t nxt_sum;
    cnt_t pos;
    cnt_t total;
  } win_t;

  // one result word
  typedef struct packed {
    cnt_t number;
    cnt_t start;
    cnt_t length;
    logic voiced;
    logic final_blk;
  } blk_t;

  // floor(sum / FRAME) > thr  <=>  sum >= (thr + 1) * FRAME
  function automatic lim_t thr_limit(thr_t thr);
    return (lim_t'(thr) + lim_t'(1)) * lim_t'(FRAME);
  endfunction

  function automatic cnt_t sat_inc(cnt_t v);
    return (&v) ? v : v + cnt_t'(1);
  endfunction

  localparam lim_t LOW_LIM_RST  = thr_limit(LOW_THR_RST);
  localparam lim_t HIGH_LIM_RST = thr_limit(HIGH_THR_RST);

endpackage

`default_nettype wire

### rtl/evs_if.sv
// ----------------------------------------------------------------------------
// evs_if
// Valid/ready channels for samples in and block words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface evs_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [evs_pkg::MAG_W-1:0] sample;
  logic                             end_of_stream;

  modport source (output valid, sample, end_of_stream, input ready);
  modport sink   (input valid, sample, end_of_stream, output ready);
endinterface

interface evs_out_if;
  logic                      valid;
  logic                      ready;
  logic [evs_pkg::CNT_W-1:0] block_number;
  logic [evs_pkg::CNT_W-1:0] block_start;
  logic [evs_pkg::CNT_W-1:0] block_length;
  logic                      voiced;
  logic                      final_block;

  modport source (output valid, block_number, block_start, block_length, voiced,
                  final_block, input ready);
  modport sink   (input valid, block_number, block_start, block_length, voiced,
                  final_block, output ready);
endinterface

`default_nettype wire

### rtl/evs_cell.sv
// ----------------------------------------------------------------------------
// evs_cell
// One stage of the magnitude delay chain; shifts on each accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module evs_cell (
  input  logic          clk_i,
  input  logic          en_i,
  input  evs_pkg::mag_t mag_i,
  output evs_pkg::mag_t mag_o
);

  evs_pkg::mag_t mag_q;
  evs_pkg::mag_t mag_d;

  always_comb begin
    mag_d = en_i ? mag_i : mag_q;
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

  assign mag_o = mag_q;

endmodule

`default_nettype wire

### rtl/evs_window.sv
// ----------------------------------------------------------------------------
// evs_window
// Magnitude chain of 2*FRAME cells, running window sums and sample count.
// ----------------------------------------------------------------------------
`default_nettype none

module evs_window (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             acc_i,
  input  logic signed [evs_pkg::MAG_W-1:0] sample_i,
  input  logic                             eos_i,
  output logic                             win_vld_o,
  output evs_pkg::win_t                    win_o
);

  evs_pkg::mag_t mag_in;
  evs_pkg::mag_t tap [evs_pkg::DEPTH];
  evs_pkg::mag_t middle;
  evs_pkg::mag_t oldest;
  evs_pkg::sum_t cur_new;
  evs_pkg::sum_t nxt_new;

  evs_pkg::sum_t cur_q, cur_d;
  evs_pkg::sum_t nxt_q, nxt_d;
  evs_pkg::cnt_t seen_q, seen_d;
  logic          win_vld_q;
  evs_pkg::win_t win_q, win_d;

  // |sample|; the most negative value maps to 32768
  assign mag_in = sample_i[evs_pkg::MAG_W-1] ?
                  (evs_pkg::mag_t'(~sample_i) + evs_pkg::mag_t'(1)) :
                  evs_pkg::mag_t'(sample_i);

  for (genvar k = 0; k < evs_pkg::DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      evs_cell u_cell (
        .clk_i (clk_i),
        .en_i  (acc_i),
        .mag_i (mag_in),
        .mag_o (tap[k])
      );
    end else begin : g_body
      evs_cell u_cell (
        .clk_i (clk_i),
        .en_i  (acc_i),
        .mag_i (tap[k-1]),
        .mag_o (tap[k])
      );
    end
  end

  // taps older than the current stream read as zero
  assign middle = (seen_q >= evs_pkg::cnt_t'(evs_pkg::FRAME)) ?
                  tap[evs_pkg::FRAME-1] : '0;
  assign oldest = (seen_q >= evs_pkg::cnt_t'(evs_pkg::DEPTH)) ?
                  tap[evs_pkg::DEPTH-1] : '0;

  assign nxt_new = nxt_q + evs_pkg::sum_t'(mag_in) - evs_pkg::sum_t'(middle);
  assign cur_new = cur_q + evs_pkg::sum_t'(middle) - evs_pkg::sum_t'(oldest);

  always_comb begin
    cur_d  = cur_q;
    nxt_d  = nxt_q;
    seen_d = seen_q;
    if (acc_i) begin
      if (eos_i) begin
        cur_d  = '0;
        nxt_d  = '0;
        seen_d = '0;
      end else begin
        cur_d  = cur_new;
        nxt_d  = nxt_new;
        seen_d = evs_pkg::sat_inc(seen_q);
      end
    end
  end

  always_comb begin
    win_d.judge   = seen_q >= evs_pkg::cnt_t'(evs_pkg::DEPTH);
    win_d.last    = eos_i;
    win_d.cur_sum = cur_new;
    win_d.nxt_sum = nxt_new;
    win_d.pos     = seen_q - evs_pkg::cnt_t'(evs_pkg::DEPTH - 1);
    win_d.total   = evs_pkg::sat_inc(seen_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      nxt_q     <= '0;
      seen_q    <= '0;
      win_vld_q <= 1'b0;
    end else begin
      cur_q     <= cur_d;
      nxt_q     <= nxt_d;
      seen_q    <= seen_d;
      win_vld_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      win_q <= win_d;
    end
  end

  assign win_vld_o = win_vld_q;
  assign win_o     = win_q;

endmodule

`default_nettype wire

### rtl/evs_judge.sv
// ----------------------------------------------------------------------------
// evs_judge
// Window levels, block open/close tracking and the output word queue.
// ----------------------------------------------------------------------------
`default_nettype none

module evs_judge (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          win_vld_i,
  input  evs_pkg::win_t win_i,
  input  evs_pkg::lim_t low_lim_i,
  input  evs_pkg::lim_t high_lim_i,
  output logic          room_o,
  output logic          out_vld_o,
  input  logic          out_rdy_i,
  output evs_pkg::blk_t blk_o
);

  logic cur_lo, cur_hi, nxt_lo, nxt_hi;
  logic close, last;
  logic pop;
  logic [1:0] npush;

  evs_pkg::cnt_t num_c, start_c, len_b;
  logic          voice_c;
  evs_pkg::blk_t blk_a, blk_b;

  logic          voice_q, voice_d;
  evs_pkg::cnt_t start_q, start_d;
  evs_pkg::cnt_t num_q, num_d;

  evs_pkg::blk_t                fifo_q [evs_pkg::FIFO_DEPTH];
  logic [evs_pkg::PTR_W-1:0]    wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [evs_pkg::FCNT_W-1:0]   cnt_q, cnt_d;

  assign cur_lo = evs_pkg::lim_t'(win_i.cur_sum) >= low_lim_i;
  assign cur_hi = evs_pkg::lim_t'(win_i.cur_sum) >= high_lim_i;
  assign nxt_lo = evs_pkg::lim_t'(win_i.nxt_sum) >= low_lim_i;
  assign nxt_hi = evs_pkg::lim_t'(win_i.nxt_sum) >= high_lim_i;

  // level 1 on current window, next window at 0 (voiced) or 2 (silent)
  assign close = win_vld_i && win_i.judge && (cur_lo ^ cur_hi) &&
                 (voice_q ? (!nxt_lo && !nxt_hi) : (nxt_lo && nxt_hi));
  assign last  = win_vld_i && win_i.last;

  assign num_c   = close ? evs_pkg::sat_inc(num_q) : num_q;
  assign start_c = close ? win_i.pos : start_q;
  assign voice_c = voice_q ^ close;
  assign len_b   = close ? (win_i.total - win_i.pos) : (win_i.total - start_q);

  always_comb begin
    blk_a.number    = num_q;
    blk_a.start     = start_q;
    blk_a.length    = win_i.pos - start_q;
    blk_a.voiced    = voice_q;
    blk_a.final_blk = 1'b0;
    blk_b.number    = num_c;
    blk_b.start     = start_c;
    blk_b.length    = len_b;
    blk_b.voiced    = voice_c;
    blk_b.final_blk = 1'b1;
  end

  always_comb begin
    if (last) begin
      voice_d = 1'b0;
      start_d = '0;
      num_d   = evs_pkg::cnt_t'(1);
    end else begin
      voice_d = voice_c;
      start_d = start_c;
      num_d   = num_c;
    end
  end

  assign npush = {1'b0, close} + {1'b0, last};
  assign pop   = (cnt_q != '0) && out_rdy_i;
  assign wr_nx = wr_q + evs_pkg::PTR_W'(1);

  always_comb begin
    wr_d  = wr_q + evs_pkg::PTR_W'(npush);
    rd_d  = rd_q + evs_pkg::PTR_W'(pop);
    cnt_d = cnt_q + evs_pkg::FCNT_W'(npush) - evs_pkg::FCNT_W'(pop);
  end

  // keep space for two words from the item in the judge stage and two more
  assign room_o = (cnt_q + (win_vld_i ? evs_pkg::FCNT_W'(2) : '0)) <=
                  evs_pkg::FCNT_W'(evs_pkg::FIFO_DEPTH - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_q <= 1'b0;
      start_q <= '0;
      num_q   <= evs_pkg::cnt_t'(1);
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
    end else begin
      voice_q <= voice_d;
      start_q <= start_d;
      num_q   <= num_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (close || last) begin
      fifo_q[wr_q] <= close ? blk_a : blk_b;
    end
    if (close && last) begin
      fifo_q[wr_nx] <= blk_b;
    end
  end

  assign out_vld_o = cnt_q != '0;
  assign blk_o     = fifo_q[rd_q];

endmodule

`default_nettype wire

### rtl/energy_voice_segmenter.sv
// ----------------------------------------------------------------------------
// energy_voice_segmenter
// Energy-based voice activity segmentation over a stream of audio samples.
//
// samp_i takes one signed sample per word, end_of_stream on the last one.
// blk_o gives one word per closed block: number, start, length, voiced,
// final_block. An item gives at most two words (a close, then the final one).
// Throughput: one sample per cycle while samp_i.ready is high, set by
// the one-step shift of the 2*FRAME-cell magnitude chain and the
// running window sums. The window state is registered, and the judge
// stage writes its words into a four-word queue that drives blk_o; while
// blk_o is stalled, samp_i.ready drops once the queue could not absorb
// two more words from each pending sample. Samples are never dropped.
// Config: cfg_we_i writes cfg_data_i to threshold cfg_idx_i
// (0 low, 1 high); write only while the block is idle.
// Reset: thresholds 512 and 1024, stream state cleared, queue empty; the
// chain needs no clearing pass, stale cells are masked by the sample count.
// ----------------------------------------------------------------------------
`default_nettype none

module energy_voice_segmenter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  evs_in_if.sink                            samp_i,
  evs_out_if.source                         blk_o,
  input  logic                              cfg_we_i,
  input  logic [evs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [evs_pkg::THR_W-1:0]         cfg_data_i
);

  evs_pkg::lim_t low_lim_q, low_lim_d;
  evs_pkg::lim_t high_lim_q, high_lim_d;

  logic          room;
  logic          acc;
  logic          win_vld;
  evs_pkg::win_t win;
  evs_pkg::blk_t blk;

  always_comb begin
    low_lim_d  = low_lim_q;
    high_lim_d = high_lim_q;
    if (cfg_we_i) begin
      unique case (evs_pkg::cfg_idx_e'(cfg_idx_i))
        evs_pkg::CFG_LOW_THR:  low_lim_d  = evs_pkg::thr_limit(cfg_data_i);
        evs_pkg::CFG_HIGH_THR: high_lim_d = evs_pkg::thr_limit(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_lim_q  <= evs_pkg::LOW_LIM_RST;
      high_lim_q <= evs_pkg::HIGH_LIM_RST;
    end else begin
      low_lim_q  <= low_lim_d;
      high_lim_q <= high_lim_d;
    end
  end

  assign acc          = samp_i.valid && room;
  assign samp_i.ready = room;

  evs_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .sample_i  (samp_i.sample),
    .eos_i     (samp_i.end_of_stream),
    .win_vld_o (win_vld),
    .win_o     (win)
  );

  evs_judge u_judge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .win_vld_i  (win_vld),
    .win_i      (win),
    .low_lim_i  (low_lim_q),
    .high_lim_i (high_lim_q),
    .room_o     (room),
    .out_vld_o  (blk_o.valid),
    .out_rdy_i  (blk_o.ready),
    .blk_o      (blk)
  );

  assign blk_o.block_number = blk.number;
  assign blk_o.block_start  = blk.start;
  assign blk_o.block_length = blk.length;
  assign blk_o.voiced       = blk.voiced;
  assign blk_o.final_block  = blk.final_blk;

endmodule

`default_nettype wire

### rtl/evs_checker.sv
// ----------------------------------------------------------------------------
// evs_checker
// Port-level checks on the block words of the segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "energy_voice_segmenter_defines.svh"

module evs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [evs_pkg::CNT_W-1:0] block_number_i,
  input logic [evs_pkg::CNT_W-1:0] block_start_i,
  input logic [evs_pkg::CNT_W-1:0] block_length_i,
  input logic                      voiced_i,
  input logic                      final_block_i
);

  logic                      acc;
  logic [3*evs_pkg::CNT_W+1:0] word;
  logic                      prev_open_q, prev_open_d;
  logic                      prev_voiced_q, prev_voiced_d;
  logic [evs_pkg::CNT_W-1:0] prev_end_q, prev_end_d;

  assign acc  = out_valid_i && out_ready_i;
  assign word = {block_number_i, block_start_i, block_length_i, voiced_i, final_block_i};

  always_comb begin
    prev_open_d   = prev_open_q;
    prev_voiced_d = prev_voiced_q;
    prev_end_d    = prev_end_q;
    if (acc) begin
      prev_open_d   = !final_block_i;
      prev_voiced_d = voiced_i;
      prev_end_d    = block_start_i + block_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_open_q   <= 1'b0;
      prev_voiced_q <= 1'b0;
      prev_end_q    <= '0;
    end else begin
      prev_open_q   <= prev_open_d;
      prev_voiced_q <= prev_voiced_d;
      prev_end_q    <= prev_end_d;
    end
  end

  `EVS_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(word), "stalled block word changed")
  `EVS_ASSERT_IMP(a_contiguous, acc && prev_open_q, block_start_i == prev_end_q, "block does not start where the previous one ended")
  `EVS_ASSERT_IMP(a_alternate, acc && prev_open_q, voiced_i != prev_voiced_q, "voiced flag did not toggle across a close")
  `EVS_ASSERT_IMP(a_fresh, acc && !prev_open_q, block_start_i == '0 && block_number_i == evs_pkg::cnt_t'(1) && !voiced_i, "stream does not open with silent block one at zero")

endmodule

bind energy_voice_segmenter evs_checker u_evs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (blk_o.valid),
  .out_ready_i    (blk_o.ready),
  .block_number_i (blk_o.block_number),
  .block_start_i  (blk_o.block_start),
  .block_length_i (blk_o.block_length),
  .voiced_i       (blk_o.voiced),
  .final_block_i  (blk_o.final_block)
);

`default_nettype wire

### bench/energy_voice_segmenter_test.sv
// ----------------------------------------------------------------------------
// energy_voice_segmenter_test
// Self-checking bench for the energy voice segmenter. A scoreboard class keeps
// its own magnitude line, window sums, level judge and open-block state, and
// predicts the block words that each accepted sample causes. Every word taken
// from blk_o is checked field by field against the oldest prediction.
// Stimulus is a few directed short streams, then short noise streams under
// several threshold settings and one long level-shaped stream. The sample
// source sends in bursts, and the block-word sink stalls on its own pattern.
// ----------------------------------------------------------------------------

module energy_voice_segmenter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAG_MAX     = 32768;

  class segment_scoreboard;
    int unsigned          thr_low;
    int unsigned          thr_high;
    logic [16:0]          mag_line [evs_pkg::DEPTH];
    int unsigned          wr_ptr;
    int unsigned          older_sum;
    int unsigned          newer_sum;
    bit                   in_voice;
    evs_pkg::cnt_t        seen_count;
    evs_pkg::cnt_t        open_start;
    evs_pkg::cnt_t        open_number;
    evs_pkg::blk_t        blocks_due[$];
    int unsigned          faults;

    function new();
      thr_low  = evs_pkg::LOW_THR_RST;
      thr_high = evs_pkg::HIGH_THR_RST;
      faults   = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (mag_line[k]) mag_line[k] = '0;
      wr_ptr      = 0;
      older_sum   = 0;
      newer_sum   = 0;
      in_voice    = 1'b0;
      seen_count  = '0;
      open_start  = '0;
      open_number = evs_pkg::cnt_t'(1);
    endfunction

    function void set_threshold(evs_pkg::cfg_idx_e idx, evs_pkg::thr_t value);
      case (idx)
        evs_pkg::CFG_LOW_THR:  thr_low  = value;
        evs_pkg::CFG_HIGH_THR: thr_high = value;
        default: ;
      endcase
    endfunction

    function evs_pkg::cnt_t bump(evs_pkg::cnt_t v);
      return (v == '1) ? v : v + evs_pkg::cnt_t'(1);
    endfunction

    function int energy_level(int unsigned sum);
      int unsigned e;
      e = sum / evs_pkg::FRAME;
      return int'(e > thr_low) + int'(e > thr_high);
    endfunction

    function void push_block(evs_pkg::cnt_t len, bit fin);
      evs_pkg::blk_t b;
      b.number    = open_number;
      b.start     = open_start;
      b.length    = len;
      b.voiced    = in_voice;
      b.final_blk = fin;
      blocks_due.push_back(b);
    endfunction

    function void take_sample(logic [15:0] raw, bit last);
      logic [16:0]   mag;
      logic [16:0]   oldest;
      logic [16:0]   middle;
      int unsigned   mid_ptr;
      evs_pkg::cnt_t t;
      evs_pkg::cnt_t pos;
      int            cur;
      int            nxt;
      mag       = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
      t         = seen_count;
      mid_ptr   = (wr_ptr + evs_pkg::FRAME) % evs_pkg::DEPTH;
      oldest    = mag_line[wr_ptr];
      middle    = mag_line[mid_ptr];
      newer_sum = newer_sum + mag - middle;
      older_sum = older_sum + middle - oldest;
      mag_line[wr_ptr] = mag;
      wr_ptr     = (wr_ptr + 1) % evs_pkg::DEPTH;
      seen_count = bump(seen_count);
      if (t >= evs_pkg::DEPTH) begin
        pos = t - evs_pkg::DEPTH + 1;
        cur = energy_level(older_sum);
        nxt = energy_level(newer_sum);
        if (cur == 1 && (in_voice ? (nxt == 0) : (nxt == 2))) begin
          push_block(pos - open_start, 1'b0);
          in_voice    = !in_voice;
          open_start  = pos;
          open_number = bump(open_number);
        end
      end
      if (last) begin
        push_block(bump(t) - open_start, 1'b1);
        clear_stream();
      end
    endfunction

    function void check_block(evs_pkg::blk_t got);
      evs_pkg::blk_t want;
      if (blocks_due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected word: number %0d start %0d length %0d voiced %0b final %0b",
                   got.number, got.start, got.length, got.voiced, got.final_blk);
        return;
      end
      want = blocks_due.pop_front();
      if (got.number !== want.number || got.start !== want.start ||
          got.length !== want.length || got.voiced !== want.voiced ||
          got.final_blk !== want.final_blk) begin
        faults++;
        if (faults <= 10) begin
          $display("word mismatch, expected: number %0d start %0d length %0d voiced %0b final %0b",
                   want.number, want.start, want.length, want.voiced, want.final_blk);
          $display("               actual:   number %0d start %0d length %0d voiced %0b final %0b",
                   got.number, got.start, got.length, got.voiced, got.final_blk);
        end
      end
    endfunction
  endclass

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              cfg_we     = 1'b0;
  evs_pkg::cfg_idx_e cfg_idx    = evs_pkg::CFG_LOW_THR;
  evs_pkg::thr_t     cfg_data   = '0;
  logic              sink_ready = 1'b0;

  evs_in_if  samp_if ();
  evs_out_if blk_if ();

  assign blk_if.ready = sink_ready;

  energy_voice_segmenter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .samp_i     (samp_if),
    .blk_o      (blk_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  segment_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned fed        = 0;
  int unsigned mode_left  = 0;
  int unsigned stall_left = 0;
  int          sink_mode  = 0;
  int unsigned cycles     = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      sink_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 500);
    end else begin
      mode_left--;
    end
    case (sink_mode)
      0: sink_ready <= 1'b1;
      1: sink_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          sink_ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_left = $urandom_range(1, 40);
          sink_ready <= 1'b0;
        end else begin
          sink_ready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && blk_if.valid && blk_if.ready)
      sb.check_block({blk_if.block_number, blk_if.block_start, blk_if.block_length,
                      blk_if.voiced, blk_if.final_block});
  end

  task automatic send_sample(logic [15:0] value, bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        samp_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 48);
    end
    samp_if.valid         <= 1'b1;
    samp_if.sample        <= value;
    samp_if.end_of_stream <= last;
    @(posedge clk_i);
    while (!samp_if.ready) @(posedge clk_i);
    sb.take_sample(value, last);
    burst_left--;
    fed++;
  endtask

  function automatic logic [15:0] signed_word(int unsigned mag);
    logic [15:0] m16;
    m16 = mag[15:0];
    if (mag == 0) return 16'h0000;
    if (mag >= MAG_MAX) return 16'h8000;
    return ($urandom_range(0, 1) == 1) ? -m16 : m16;
  endfunction

  // magnitude whose window average lands in the wanted energy level
  function automatic int unsigned level_mag(int level);
    int unsigned lo_b;
    int unsigned hi_b;
    lo_b = (sb.thr_low < sb.thr_high) ? sb.thr_low : sb.thr_high;
    hi_b = (sb.thr_low < sb.thr_high) ? sb.thr_high : sb.thr_low;
    if (lo_b > MAG_MAX) lo_b = MAG_MAX;
    if (level == 2 && hi_b < MAG_MAX) return $urandom_range(MAG_MAX, hi_b + 1);
    if (level == 1 && lo_b < hi_b && lo_b < MAG_MAX)
      return $urandom_range((hi_b > MAG_MAX) ? MAG_MAX : hi_b, lo_b + 1);
    return $urandom_range(lo_b, 0);
  endfunction

  task automatic noise_stream(int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      send_sample(16'($urandom), k == len - 1);
  endtask

  task automatic shaped_stream(int unsigned len);
    int unsigned k;
    int unsigned seg;
    int          level;
    k     = 0;
    level = $urandom_range(0, 2);
    while (k < len) begin
      seg = $urandom_range(20, 260);
      while (seg > 0 && k < len) begin
        if ($urandom_range(0, 39) == 0)
          send_sample(16'($urandom), k == len - 1);
        else
          send_sample(signed_word(level_mag(level)), k == len - 1);
        k++;
        seg--;
      end
      level = (level + $urandom_range(1, 2)) % 3;
    end
  endtask

  task automatic run_phase(bit with_shaped);
    int unsigned phase_start;
    phase_start = fed;
    while (fed - phase_start < 20)
      noise_stream($urandom_range(1, 16));
    if (with_shaped)
      shaped_stream($urandom_range(evs_pkg::DEPTH + 1, evs_pkg::DEPTH + 180));
  endtask

  task automatic wait_idle();
    samp_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.blocks_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_thresholds(evs_pkg::thr_t lo, evs_pkg::thr_t hi);
    cfg_we   <= 1'b1;
    cfg_idx  <= evs_pkg::CFG_LOW_THR;
    cfg_data <= lo;
    @(posedge clk_i);
    cfg_idx  <= evs_pkg::CFG_HIGH_THR;
    cfg_data <= hi;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    sb.set_threshold(evs_pkg::CFG_LOW_THR, lo);
    sb.set_threshold(evs_pkg::CFG_HIGH_THR, hi);
  endtask

  initial begin
    evs_pkg::thr_t lo;
    evs_pkg::thr_t hi;
    samp_if.valid         <= 1'b0;
    samp_if.sample        <= '0;
    samp_if.end_of_stream <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-sample streams at the sample extremes, then a few short streams
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0001, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b1);
    send_sample(16'h8001, 1'b0);
    send_sample(16'h4000, 1'b0);
    send_sample(16'hC000, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);

    run_phase(1'b0);
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin lo = 16'd0;     hi = 16'd0;     end
        1: begin lo = 16'd32768; hi = 16'd32768; end
        2: begin lo = 16'd0;     hi = 16'd32768; end
        3: begin lo = 16'd32768; hi = 16'd0;     end
        4: begin
          lo = evs_pkg::thr_t'($urandom_range(50, 8000));
          hi = evs_pkg::thr_t'($urandom_range(int'(lo) + 50, 20000));
        end
        5: begin
          hi = evs_pkg::thr_t'($urandom_range(50, 8000));
          lo = evs_pkg::thr_t'($urandom_range(int'(hi) + 50, 20000));
        end
        default: begin lo = 16'd300; hi = 16'd301; end
      endcase
      wait_idle();
      write_thresholds(lo, hi);
      run_phase(p == 4);
    end

    samp_if.valid <= 1'b0;
    while (sb.blocks_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.faults == 0 && sb.blocks_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### energy_voice_segmenter.f
+incdir+rtl
rtl/evs_pkg.sv
rtl/evs_if.sv
rtl/evs_cell.sv
rtl/evs_window.sv
rtl/evs_judge.sv
rtl/energy_voice_segmenter.sv
rtl/evs_checker.sv
bench/energy_voice_segmenter_test.sv
